// ===== hw/rtl/columnar_transposition_cipher_core_macros.svh =====
// Assertion macros used by the port checker of the transposition core.
// Depends on nothing; the including file supplies clock, reset and properties.
`ifndef COLUMNAR_TRANSPOSITION_CIPHER_CORE_MACROS_SVH
`define COLUMNAR_TRANSPOSITION_CIPHER_CORE_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define CTC_ASSERT_ON(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define CTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ctc_pkg.sv =====
// Types and constants of the columnar transposition core.
// Used by the controller, the datapath, the top level and the port checker.
package ctc_pkg;

    localparam int BYTE_W     = 8;
    localparam int KEY_W      = 9;
    localparam int LEN_W      = 9;
    localparam int ROWS_W     = 10;
    localparam int LOAD_W     = 10;
    localparam int PROD_RK_W  = 2 * KEY_W;
    localparam int PROD_CR_W  = KEY_W + ROWS_W;
    localparam int IDX_W      = PROD_CR_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLUMNS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LENGTH = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] in_byte;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
        logic              status;
    } t_result;

    typedef enum logic [2:0] {
        S_INIT,
        S_DIV,
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load_div;
        logic step_div;
        logic take_item;
        logic read_mem;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic is_fetch;
        logic emit;
        logic cfg_restart;
    } t_dp_status;

endpackage

// ===== hw/rtl/ctc_controller.sv =====
// Sequencing state machine of the columnar transposition core.
// Depends on ctc_pkg for the state type and the command and status structs.
module ctc_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  ctc_pkg::t_dp_status i_status,
    output ctc_pkg::t_dp_cmd    o_cmd,
    output logic                busy,
    output logic                o_result_valid
);
    import ctc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.load_div = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.step_div = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.take_item = 1'b1;
                    if (i_status.is_fetch) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.read_mem = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        if (i_status.cfg_restart) begin
            n_state = S_INIT;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_OUT) && i_status.emit;

endmodule

// ===== hw/rtl/ctc_datapath.sv =====
// Configuration registers, counters, row divider and message store of the core.
// Depends on ctc_pkg; driven by commands from ctc_controller.
module ctc_datapath #(
    parameter int MAX_LENGTH  = 511,
    parameter int STORE_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ctc_pkg::t_dp_cmd                   i_cmd,
    input  ctc_pkg::t_item                     i_item,
    input  logic                               i_cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output ctc_pkg::t_dp_status                o_status,
    output ctc_pkg::t_result                   o_result
);
    import ctc_pkg::*;

    localparam int ADDR_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LenCapInt  = (MAX_LENGTH < (2 ** LEN_W - 1)) ? MAX_LENGTH
                                                                : (2 ** LEN_W - 1);
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LenCapInt);

    logic [BYTE_W-1:0] mem [STORE_DEPTH];

    logic              r_decrypt;
    logic [KEY_W-1:0]  r_key;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_rem;
    logic [ROWS_W-1:0] r_rows;
    logic [LOAD_W-1:0] r_needed;
    logic [LOAD_W-1:0] r_load;
    logic [KEY_W-1:0]  r_row;
    logic [KEY_W-1:0]  r_col;
    logic [ADDR_W-1:0] r_addr;
    logic              r_zero;
    logic              r_last;
    logic              r_stat;
    logic              r_emit;
    logic [BYTE_W-1:0] r_rd;

    logic [KEY_W-1:0]     n_row;
    logic [KEY_W-1:0]     n_col;
    logic [IDX_W-1:0]     n_idx;
    logic                 n_zero;
    logic                 n_last;
    logic                 n_stat;
    logic                 n_emit;
    logic [LOAD_W-1:0]    n_needed;

    logic                 w_cfg_hit;
    logic                 w_div_done;
    logic                 w_ready;
    logic                 w_load_we;
    logic [PROD_RK_W-1:0] w_prod_rk;
    logic [PROD_CR_W-1:0] w_prod_cr;
    logic [IDX_W-1:0]     w_pos;
    logic [IDX_W-1:0]     w_idx_dec;
    logic [ROWS_W-1:0]    w_row_inc;
    logic [KEY_W:0]       w_col_inc;
    logic [KEY_W-1:0]     w_cfg_key;
    logic [LEN_W-1:0]     w_cfg_len;

    always_comb begin
        case (i_cfg_index)
            CFG_DECRYPT_MODE:   w_cfg_hit = i_cfg_we;
            CFG_KEY_COLUMNS:    w_cfg_hit = i_cfg_we;
            CFG_MESSAGE_LENGTH: w_cfg_hit = i_cfg_we;
            default:            w_cfg_hit = 1'b0;
        endcase
    end

    assign w_cfg_key = (i_cfg_data == '0) ? KEY_W'(1) : KEY_W'(i_cfg_data);
    assign w_cfg_len = (32'(i_cfg_data) > MAX_LENGTH) ? LEN_CAP : LEN_W'(i_cfg_data);

    assign w_div_done = (r_rem < r_key);
    assign n_needed   = r_decrypt ? (LOAD_W'(r_len) - LOAD_W'(r_rem) + LOAD_W'(r_key))
                                  : LOAD_W'(r_len);

    assign w_ready   = (r_load >= r_needed);
    assign w_prod_rk = r_row * r_key;
    assign w_prod_cr = r_col * r_rows;
    assign w_pos     = IDX_W'(w_prod_rk) + IDX_W'(r_col);
    assign w_idx_dec = IDX_W'(w_prod_cr) + IDX_W'(r_row);
    assign w_row_inc = ROWS_W'(r_row) + ROWS_W'(1);
    assign w_col_inc = (KEY_W + 1)'(r_col) + (KEY_W + 1)'(1);

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_idx  = w_pos;
        n_zero = 1'b0;
        n_last = 1'b0;
        n_stat = 1'b0;
        n_emit = 1'b1;
        if (!w_ready) begin
            n_stat = 1'b1;
            n_zero = 1'b1;
        end else if (!r_decrypt) begin
            n_emit = (r_col < r_key);
            n_zero = (w_pos >= IDX_W'(r_len)) || (32'(w_pos) >= STORE_DEPTH);
            n_last = (w_col_inc == (KEY_W + 1)'(r_key)) && (w_row_inc == r_rows);
            if (n_emit) begin
                if (w_row_inc >= r_rows) begin
                    n_row = '0;
                    n_col = r_col + KEY_W'(1);
                end else begin
                    n_row = w_row_inc[KEY_W-1:0];
                end
            end
        end else begin
            n_emit = (w_pos < IDX_W'(r_len));
            n_idx  = w_idx_dec;
            n_zero = (32'(w_idx_dec) >= STORE_DEPTH);
            n_last = ((w_pos + IDX_W'(1)) == IDX_W'(r_len));
            if (n_emit) begin
                if (w_col_inc >= (KEY_W + 1)'(r_key)) begin
                    n_col = '0;
                    n_row = r_row + KEY_W'(1);
                end else begin
                    n_col = w_col_inc[KEY_W-1:0];
                end
            end
        end
    end

    assign w_load_we = i_cmd.take_item && (i_item.command == CMD_LOAD) && !w_cfg_hit
                       && (r_load < r_needed) && (32'(r_load) < STORE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
            r_key     <= KEY_W'(1);
            r_len     <= LEN_W'(2);
            r_rem     <= '0;
            r_rows    <= '0;
            r_needed  <= '0;
            r_load    <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_emit    <= 1'b0;
        end else if (w_cfg_hit) begin
            case (i_cfg_index)
                CFG_DECRYPT_MODE:   r_decrypt <= i_cfg_data[0];
                CFG_KEY_COLUMNS:    r_key     <= w_cfg_key;
                CFG_MESSAGE_LENGTH: r_len     <= w_cfg_len;
                default:            r_decrypt <= r_decrypt;
            endcase
            r_load <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            if (i_cmd.load_div) begin
                r_rem  <= r_len;
                r_rows <= ROWS_W'(1);
            end
            if (i_cmd.step_div) begin
                if (!w_div_done) begin
                    r_rem  <= r_rem - LEN_W'(r_key);
                    r_rows <= r_rows + ROWS_W'(1);
                end else begin
                    r_needed <= n_needed;
                end
            end
            if (i_cmd.take_item) begin
                if (i_item.command == CMD_FETCH) begin
                    r_row  <= n_row;
                    r_col  <= n_col;
                    r_emit <= n_emit;
                end else if (r_load < r_needed) begin
                    r_load <= r_load + LOAD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_addr <= ADDR_W'(n_idx);
            r_zero <= n_zero;
            r_last <= n_last;
            r_stat <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            mem[ADDR_W'(r_load)] <= i_item.in_byte;
        end
        if (i_cmd.read_mem) begin
            r_rd <= mem[r_addr];
        end
    end

    assign o_status.div_done    = w_div_done;
    assign o_status.is_fetch    = (i_item.command == CMD_FETCH);
    assign o_status.emit        = r_emit;
    assign o_status.cfg_restart = w_cfg_hit;

    assign o_result.out_byte  = r_zero ? '0 : r_rd;
    assign o_result.last_byte = r_last;
    assign o_result.status    = r_stat;

endmodule

// ===== hw/rtl/columnar_transposition_cipher_core.sv =====
// Top level of the columnar transposition core: controller plus datapath.
// A load leaves busy low; a fetch holds busy through the read and output states,
// and its result strobes in the output state if it emits, after the registered
// read of the message store. After reset or a write to a defined register the row
// divider subtracts K once a cycle while busy is high; the store is never cleared.
// Reset is synchronous and active low; results cannot be stalled by the receiver.
module columnar_transposition_cipher_core #(
    parameter int MAX_LENGTH  = 511,
    parameter int STORE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ctc_pkg::t_item                 i_item,
    output logic                           o_result_valid,
    output ctc_pkg::t_result               o_result,
    input  logic                           i_cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ctc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    ctc_controller u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_status       (w_status),
        .o_cmd          (w_cmd),
        .busy           (busy),
        .o_result_valid (o_result_valid)
    );

    ctc_datapath #(
        .MAX_LENGTH  (MAX_LENGTH),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (w_status),
        .o_result    (o_result)
    );

endmodule

// ===== hw/rtl/ctc_port_checker.sv =====
// Port-level checks of the columnar transposition core, bound to the top level.
// Depends on ctc_pkg and columnar_transposition_cipher_core_macros.svh.
`include "columnar_transposition_cipher_core_macros.svh"

module ctc_port_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input ctc_pkg::t_item                 i_item,
    input logic                           o_result_valid,
    input ctc_pkg::t_result               o_result,
    input logic                           i_cfg_we,
    input logic [ctc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [ctc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ctc_pkg::*;

    logic w_fetch_take;
    logic w_cfg_any;

    assign w_fetch_take = start && !busy && (i_item.command == CMD_FETCH);
    assign w_cfg_any    = i_cfg_we && (i_cfg_index != '1) && (i_cfg_data == i_cfg_data);

    `CTC_ASSERT_ON(a_strobe_while_busy, i_clk, i_rst_n, o_result_valid |-> busy, "result transfer while not busy")
    `CTC_ASSERT_ON(a_strobe_single, i_clk, i_rst_n, o_result_valid |=> !o_result_valid, "result strobe held two cycles")
    `CTC_ASSERT_ON(a_not_ready_clean, i_clk, i_rst_n, (o_result_valid && o_result.status) |-> (o_result.out_byte == '0 && !o_result.last_byte), "not-ready result carries data")
    `CTC_ASSERT_ON(a_strobe_after_fetch, i_clk, i_rst_n, o_result_valid |-> ($past(w_fetch_take, 2) && !$past(w_cfg_any, 1)), "result without a fetch transfer two cycles before")

endmodule

bind columnar_transposition_cipher_core ctc_port_checker u_port_checker (.*);
